/* sv/atp_pkg.sv */
`default_nettype none

package atp_pkg;

  // Field widths of the channel words.
  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int PIX_W      = 8;
  localparam int ENTRY_W    = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Internal arithmetic widths.
  localparam int SCALE_W  = 17;            // scale bounds after widening
  localparam int DIFF_W   = 18;            // sample minus scale minimum, scale span
  localparam int SPAN_W   = 10;            // row span and signed row bounds
  localparam int PROD_W   = 28;            // product of offset and row span
  localparam int DEN_W    = 17;            // magnitude of the scale span
  localparam int DIV_STEP = 4;             // quotient bits per divider cycle
  localparam int Q_W      = PROD_W + 1;    // signed quotient
  localparam int ROW_W    = PROD_W + 2;    // signed row before clamping

  localparam int DEPTH_DEF = 64;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32000;
  localparam int AXIS_ROWS = 9;
  localparam logic [PIX_W-1:0] LEFT_X = 8'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLUMN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_ROW   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SHOWN   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RANGE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS  = 4'd7;

  // Configuration reset values.
  localparam logic [PIX_W-1:0] TOP_ROW_RST      = 8'd0;
  localparam logic [PIX_W-1:0] RIGHT_COLUMN_RST = 8'd127;
  localparam logic [PIX_W-1:0] BOTTOM_ROW_RST   = 8'd63;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          now_ms;
    logic                       sampling_on;
  } in_word_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]         entry_index;
    logic [PIX_W-1:0]           column_x;
    logic [PIX_W-1:0]           row_y;
    logic signed [SAMPLE_W-1:0] scale_low;
    logic signed [SAMPLE_W-1:0] scale_high;
    logic signed [SAMPLE_W-1:0] window_low;
    logic signed [SAMPLE_W-1:0] window_high;
    logic                       last;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;    // input word taken this cycle
    logic rd;         // read the store at the controller's index
    logic scan;       // the read feeds the min/max scan
    logic scale;      // settle the scale bounds
    logic mul;        // form offset times span for the entry just read
    logic div_start;  // start the divider on the product
    logic out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic take;       // the last input word was accepted as a sample
    logic div_done;   // quotient ready
    logic out_free;   // result register can take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

/* sv/atp_chan_if.sv */
`default_nettype none

interface atp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/atp_div.sv */
`default_nettype none

// Restoring divider on magnitudes, DIV_STEP quotient bits per cycle.
module atp_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [atp_pkg::PROD_W-1:0]      num,
  input  wire logic [atp_pkg::DEN_W-1:0]       den,
  input  wire logic                            neg,
  output logic                                 done,
  output logic signed [atp_pkg::Q_W-1:0]       quo
);

  localparam int NUM_W = atp_pkg::PROD_W;
  localparam int DEN_W = atp_pkg::DEN_W;
  localparam int STEP  = atp_pkg::DIV_STEP;
  localparam int ITERS = NUM_W / STEP;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] nq_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] nq_nxt;

  // Each step shifts one numerator bit into the remainder and takes one quotient bit.
  always_comb begin
    logic [DEN_W:0] sh;
    rem_nxt = rem_r;
    nq_nxt  = nq_r;
    for (int k = 0; k < STEP; k++) begin
      sh     = {rem_nxt, nq_nxt[NUM_W-1]};
      nq_nxt = {nq_nxt[NUM_W-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        sh        = sh - {1'b0, den_r};
        nq_nxt[0] = 1'b1;
      end
      rem_nxt = sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(ITERS);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      nq_r  <= num;
      den_r <= den;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, nq_r}) : $signed({1'b0, nq_r});

endmodule

`default_nettype wire

/* sv/atp_dp.sv */
`default_nettype none

module atp_dp #(
  parameter int DEPTH = atp_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire atp_pkg::cfg_word_t          cfg_word,
  input  wire atp_pkg::in_word_t           in_word,
  input  wire atp_pkg::cmd_t               cmd,
  input  wire logic [$clog2(DEPTH)-1:0]    idx,
  output atp_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output atp_pkg::out_word_t               out_word
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SW     = atp_pkg::SAMPLE_W;
  localparam int PIX_W  = atp_pkg::PIX_W;
  localparam int SPAN_W = atp_pkg::SPAN_W;
  localparam int ROW_W  = atp_pkg::ROW_W;
  localparam int Q_W    = atp_pkg::Q_W;

  typedef struct packed {
    logic [PIX_W-1:0]     tag;     // column at write time plus the accept count
    logic signed [SW-1:0] sample;
  } mem_word_t;

  function automatic logic signed [SW-1:0] sat16(input logic signed [SW-1:0] v);
    if (v > atp_pkg::SAMPLE_MAX) return atp_pkg::SAMPLE_MAX;
    if (v < atp_pkg::SAMPLE_MIN) return atp_pkg::SAMPLE_MIN;
    return v;
  endfunction

  // Configuration registers.
  logic [PIX_W-1:0]     top_row_r;
  logic [PIX_W-1:0]     right_col_r;
  logic [PIX_W-1:0]     bottom_row_r;
  logic                 axis_r;
  logic                 auto_r;
  logic signed [SW-1:0] range_low_r;
  logic signed [SW-1:0] range_high_r;
  logic [SW-1:0]        interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_row_r    <= atp_pkg::TOP_ROW_RST;
      right_col_r  <= atp_pkg::RIGHT_COLUMN_RST;
      bottom_row_r <= atp_pkg::BOTTOM_ROW_RST;
      axis_r       <= 1'b1;
      auto_r       <= 1'b1;
      range_low_r  <= '0;
      range_high_r <= '0;
      interval_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_word.index)
        atp_pkg::CFG_TOP_ROW:      top_row_r    <= cfg_word.value[PIX_W-1:0];
        atp_pkg::CFG_RIGHT_COLUMN: right_col_r  <= cfg_word.value[PIX_W-1:0];
        atp_pkg::CFG_BOTTOM_ROW:   bottom_row_r <= cfg_word.value[PIX_W-1:0];
        atp_pkg::CFG_AXIS_SHOWN:   axis_r       <= cfg_word.value[0];
        atp_pkg::CFG_AUTO_RANGE:   auto_r       <= cfg_word.value[0];
        atp_pkg::CFG_RANGE_LOW:    range_low_r  <= $signed(cfg_word.value);
        atp_pkg::CFG_RANGE_HIGH:   range_high_r <= $signed(cfg_word.value);
        atp_pkg::CFG_INTERVAL_MS:  interval_r   <= cfg_word.value;
        default: ;
      endcase
    end
  end

  // Sample acceptance and store bookkeeping.
  logic [atp_pkg::TIME_W-1:0] last_ms_r;
  logic [IDX_W-1:0]           wi_r;
  logic [PIX_W-1:0]           acc_r;
  logic [DEPTH-1:0]           vld_r;
  logic                       take_r;

  logic [atp_pkg::TIME_W-1:0] elapsed;
  logic                       take;
  logic [IDX_W-1:0]           wi_nxt;
  logic [PIX_W-1:0]           acc_nxt;
  logic signed [SW-1:0]       in_sat;

  assign elapsed = in_word.now_ms - last_ms_r;
  assign take    = in_word.sampling_on && (elapsed >= atp_pkg::TIME_W'(interval_r));
  assign wi_nxt  = (wi_r == IDX_W'(DEPTH - 1)) ? '0 : wi_r + IDX_W'(1);
  assign acc_nxt = acc_r + PIX_W'(1);
  assign in_sat  = sat16(in_word.sample);

  mem_word_t mem [DEPTH];
  mem_word_t rd_word_r;
  logic      rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in && take) begin
      mem[wi_nxt] <= '{tag: right_col_r + acc_nxt, sample: in_sat};
    end
    if (cmd.rd) begin
      rd_word_r <= mem[idx];
      rd_vld_r  <= vld_r[idx];
    end
  end

  // An entry never written reads as its reset contents.
  logic signed [SW-1:0] ent_sample;
  logic [PIX_W-1:0]     ent_tag;

  assign ent_sample = rd_vld_r ? rd_word_r.sample : '0;
  assign ent_tag    = rd_vld_r ? rd_word_r.tag : atp_pkg::LEFT_X;

  // Scan and scale state.
  logic                              fold_r;
  logic signed [SW-1:0]              lo_r;
  logic signed [SW-1:0]              hi_r;
  logic signed [atp_pkg::SCALE_W-1:0] scale_min_r;
  logic signed [atp_pkg::SCALE_W-1:0] scale_max_r;
  logic signed [SW-1:0]              data_min_r;
  logic signed [SW-1:0]              data_max_r;

  logic signed [atp_pkg::SCALE_W-1:0] mn_a, mx_a, mn_b, mx_b;
  logic signed [SW-1:0]              rl_sat, rh_sat;

  always_comb begin
    rl_sat = sat16(range_low_r);
    rh_sat = sat16(range_high_r);
    mn_a   = take_r ? {lo_r[SW-1], lo_r} : scale_min_r;
    mx_a   = take_r ? {hi_r[SW-1], hi_r} : scale_max_r;
    if (!auto_r) begin
      mn_a = {rl_sat[SW-1], rl_sat};
      mx_a = {rh_sat[SW-1], rh_sat};
    end
    mn_b = mn_a;
    mx_b = mx_a;
    if (mn_a == mx_a) begin
      mn_b = mn_a - atp_pkg::SCALE_W'(1);
      mx_b = mx_a + atp_pkg::SCALE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ms_r   <= '0;
      wi_r        <= '0;
      acc_r       <= '0;
      vld_r       <= '0;
      take_r      <= 1'b0;
      fold_r      <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      scale_min_r <= '0;
      scale_max_r <= '0;
      data_min_r  <= '0;
      data_max_r  <= '0;
    end else begin
      fold_r <= cmd.rd && cmd.scan;
      if (cmd.load_in) begin
        take_r <= take;
        lo_r   <= atp_pkg::SAMPLE_MAX;
        hi_r   <= atp_pkg::SAMPLE_MIN;
        if (take) begin
          last_ms_r     <= in_word.now_ms;
          wi_r          <= wi_nxt;
          acc_r         <= acc_nxt;
          vld_r[wi_nxt] <= 1'b1;
        end
      end
      if (fold_r) begin
        if (ent_sample < lo_r) lo_r <= ent_sample;
        if (ent_sample > hi_r) hi_r <= ent_sample;
      end
      if (cmd.scale) begin
        scale_min_r <= mn_b;
        scale_max_r <= mx_b;
        if (take_r) begin
          data_min_r <= lo_r;
          data_max_r <= hi_r;
        end
      end
    end
  end

  // Plot geometry.
  logic signed [SPAN_W-1:0]         top_s;
  logic signed [SPAN_W-1:0]         bot_s;
  logic signed [SPAN_W-1:0]         span;
  logic signed [atp_pkg::DIFF_W-1:0] den;
  logic signed [atp_pkg::DIFF_W-1:0] den_abs;
  logic                             den_zero;

  assign top_s    = $signed({2'b00, top_row_r});
  assign bot_s    = axis_r ? $signed({2'b00, bottom_row_r}) - SPAN_W'(atp_pkg::AXIS_ROWS)
                           : $signed({2'b00, bottom_row_r});
  assign span     = top_s - bot_s;
  assign den      = {scale_max_r[atp_pkg::SCALE_W-1], scale_max_r}
                  - {scale_min_r[atp_pkg::SCALE_W-1], scale_min_r};
  assign den_abs  = den[atp_pkg::DIFF_W-1] ? -den : den;
  assign den_zero = (den == '0);

  // Offset times span for the entry just read.
  logic signed [atp_pkg::DIFF_W-1:0] diff;
  logic signed [atp_pkg::PROD_W-1:0] prod;
  logic signed [atp_pkg::PROD_W-1:0] prod_r;
  logic signed [atp_pkg::PROD_W-1:0] prod_abs;
  logic [PIX_W-1:0]                  col_r;

  assign diff     = {ent_sample[SW-1], ent_sample[SW-1], ent_sample}
                  - {scale_min_r[atp_pkg::SCALE_W-1], scale_min_r};
  assign prod     = diff * span;
  assign prod_abs = prod_r[atp_pkg::PROD_W-1] ? -prod_r : prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod;
      col_r  <= ent_tag - acc_r;
    end
  end

  logic                  div_done;
  logic signed [Q_W-1:0] quo;

  atp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_abs),
    .den   (den_abs[atp_pkg::DEN_W-1:0]),
    .neg   (prod_r[atp_pkg::PROD_W-1] ^ den[atp_pkg::DIFF_W-1]),
    .done  (div_done),
    .quo   (quo)
  );

  // Row: quotient plus bottom (bottom alone on a zero scale span), then clamped to the top first and the bottom second.
  logic signed [ROW_W-1:0] bot_w;
  logic signed [ROW_W-1:0] top_w;
  logic signed [ROW_W-1:0] row_sum;
  logic signed [ROW_W-1:0] row;

  assign bot_w   = {{(ROW_W - SPAN_W){bot_s[SPAN_W-1]}}, bot_s};
  assign top_w   = $signed(ROW_W'(top_row_r));
  assign row_sum = den_zero ? bot_w : {quo[Q_W-1], quo} + bot_w;

  always_comb begin
    row = row_sum;
    if (row_sum < top_w) begin
      row = top_w;
    end else if (row_sum > bot_w) begin
      row = bot_w;
    end
  end

  // Result register.
  logic                 out_valid_r;
  atp_pkg::out_word_t   out_word_r;
  logic                 out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r.entry_index <= atp_pkg::ENTRY_W'(idx);
      out_word_r.column_x    <= col_r;
      out_word_r.row_y       <= row[PIX_W-1:0];
      out_word_r.scale_low   <= scale_min_r[SW-1:0];
      out_word_r.scale_high  <= scale_max_r[SW-1:0];
      out_word_r.window_low  <= data_min_r;
      out_word_r.window_high <= data_max_r;
      out_word_r.last        <= (idx == IDX_W'(DEPTH - 1));
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;
  assign sts.take     = take_r;
  assign sts.div_done = div_done;
  assign sts.out_free = out_free;

endmodule

`default_nettype wire

/* sv/atp_ctrl.sv */
`default_nettype none

module atp_ctrl #(
  parameter int DEPTH = atp_pkg::DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire atp_pkg::sts_t             sts,
  output atp_pkg::cmd_t                  cmd,
  output logic [$clog2(DEPTH)-1:0]       idx
);

  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_SCALE    = 4'd4;
  localparam logic [3:0] S_RD       = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_DIV0     = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             at_last;

  assign at_last = (cnt_r == IDX_W'(DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = sts.take ? S_SCAN : S_SCALE;
      end
      S_SCAN: begin
        cmd.rd   = 1'b1;
        cmd.scan = 1'b1;
        if (at_last) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN_END;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_SCAN_END: begin
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (at_last) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign idx = cnt_r;

endmodule

`default_nettype wire

/* sv/autoscaled_trace_plotter_unit.sv */
`default_nettype none

// Channel   Dir  Payload (data)                                     Transfer
// in_ch     in   sample, now_ms, sampling_on                        valid & ready
// out_ch    out  entry_index, column_x, row_y, scale_low/high,      valid & ready
//                window_low/high, last
// cfg_ch    in   index, value                                       valid & ready (ready tied high)
//
// Every input word, accepted as a sample or not, yields DEPTH result words. The min/max scan
// over the store runs only when the sample is accepted; each entry then passes the read,
// multiply, divider start, divide and output states, waiting on the divider in the divide state.
// Reset is synchronous; per-entry valid flags make unwritten store entries read as their
// reset contents, so the store needs no clearing pass after reset.
// A stalled out_ch holds the controller in its output state; in_ch.ready is high only in idle.
module autoscaled_trace_plotter_unit #(
  parameter int DEPTH = atp_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  atp_chan_if.sink   in_ch,
  atp_chan_if.source out_ch,
  atp_chan_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(DEPTH);

  atp_pkg::cmd_t       cmd;
  atp_pkg::sts_t       sts;
  logic [IDX_W-1:0]    idx;
  logic                in_ready;
  logic                out_valid;
  atp_pkg::out_word_t  out_word;
  atp_pkg::in_word_t   in_word;
  atp_pkg::cfg_word_t  cfg_word;

  // Configuration writes land directly in the registers, so the port never back-pressures.
  assign cfg_ch.ready = 1'b1;
  assign cfg_word     = cfg_ch.data;
  assign in_word      = in_ch.data;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  // The controller sequences check, scan, scale and the per-entry row computation.
  atp_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  // The datapath holds the configuration, the sample store, the scale and the divider.
  atp_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_word  (cfg_word),
    .in_word   (in_word),
    .cmd       (cmd),
    .idx       (idx),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  // The result register is loaded only when it is empty or being drained.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten while full");

  // A started division never reports done in the following cycle.
  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done flag survived a restart");

  // Once a word is taken the unit stays busy until its results are queued.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again right after a word");

  // The controller issues at most one datapath operation per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.rd, cmd.scale, cmd.mul, cmd.div_start, cmd.out_load}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire
